// ----- src/rial_pkg.sv -----
// Shared types and constants for the integer ALU with register file.
package rial_pkg;

  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 72;
  localparam int unsigned RIDX_W = 5;

  localparam logic [4:0] OP_ILLEGAL = 5'd0;
  localparam logic [4:0] OP_LI   = 5'd1;
  localparam logic [4:0] OP_AND  = 5'd2;
  localparam logic [4:0] OP_ANDI = 5'd3;
  localparam logic [4:0] OP_OR   = 5'd4;
  localparam logic [4:0] OP_ORI  = 5'd5;
  localparam logic [4:0] OP_XOR  = 5'd6;
  localparam logic [4:0] OP_XORI = 5'd7;
  localparam logic [4:0] OP_SLT  = 5'd8;
  localparam logic [4:0] OP_SLTI = 5'd9;
  localparam logic [4:0] OP_SLTU = 5'd10;
  localparam logic [4:0] OP_SLTIU = 5'd11;
  localparam logic [4:0] OP_SRL  = 5'd12;
  localparam logic [4:0] OP_SRLI = 5'd13;
  localparam logic [4:0] OP_SLL  = 5'd14;
  localparam logic [4:0] OP_SLLI = 5'd15;
  localparam logic [4:0] OP_ADD  = 5'd16;
  localparam logic [4:0] OP_ADDI = 5'd17;
  localparam logic [4:0] OP_SUB  = 5'd18;
  localparam logic [4:0] OP_MUL  = 5'd19;
  localparam logic [4:0] OP_DIV  = 5'd20;
  localparam logic [4:0] OP_REM  = 5'd21;

  localparam logic [3:0] K_NOP  = 4'd0;
  localparam logic [3:0] K_LI   = 4'd1;
  localparam logic [3:0] K_AND  = 4'd2;
  localparam logic [3:0] K_OR   = 4'd3;
  localparam logic [3:0] K_XOR  = 4'd4;
  localparam logic [3:0] K_SLT  = 4'd5;
  localparam logic [3:0] K_SLTU = 4'd6;
  localparam logic [3:0] K_SRL  = 4'd7;
  localparam logic [3:0] K_SLL  = 4'd8;
  localparam logic [3:0] K_ADD  = 4'd9;
  localparam logic [3:0] K_SUB  = 4'd10;
  localparam logic [3:0] K_MUL  = 4'd11;
  localparam logic [3:0] K_DIV  = 4'd12;
  localparam logic [3:0] K_REM  = 4'd13;

  typedef struct packed {
    logic [3:0]        kind;
    logic              use_imm;
    logic              legal;
    logic [RIDX_W-1:0] rd;
    logic [RIDX_W-1:0] rs1;
    logic [RIDX_W-1:0] rs2;
    logic [31:0]       imm;
  } item_t;

endpackage

// ----- src/rial_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rial_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rial_front.sv -----
// Front end: accept instructions, classify them, hold them in a short queue.
module rial_front
  import rial_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  output item_t           head,
  output logic            head_vld,
  input  logic            pop
);

  localparam int unsigned QD = 4;
  localparam int unsigned PW = $clog2(QD);

  item_t         q_r [QD];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push;
  item_t         dec;
  logic [4:0]    op;

  assign op = in_tdata[4:0];

  always_comb begin
    dec.rd   = in_tdata[9:5];
    dec.rs1  = in_tdata[14:10];
    dec.rs2  = in_tdata[19:15];
    dec.imm  = in_tdata[51:20];
    dec.legal   = 1'b1;
    dec.use_imm = 1'b0;
    dec.kind    = K_NOP;
    unique case (op)
      OP_LI:   begin dec.kind = K_LI;   dec.use_imm = 1'b1; end
      OP_AND:  dec.kind = K_AND;
      OP_ANDI: begin dec.kind = K_AND;  dec.use_imm = 1'b1; end
      OP_OR:   dec.kind = K_OR;
      OP_ORI:  begin dec.kind = K_OR;   dec.use_imm = 1'b1; end
      OP_XOR:  dec.kind = K_XOR;
      OP_XORI: begin dec.kind = K_XOR;  dec.use_imm = 1'b1; end
      OP_SLT:  dec.kind = K_SLT;
      OP_SLTI: begin dec.kind = K_SLT;  dec.use_imm = 1'b1; end
      OP_SLTU: dec.kind = K_SLTU;
      OP_SLTIU: begin dec.kind = K_SLTU; dec.use_imm = 1'b1; end
      OP_SRL:  dec.kind = K_SRL;
      OP_SRLI: begin dec.kind = K_SRL;  dec.use_imm = 1'b1; end
      OP_SLL:  dec.kind = K_SLL;
      OP_SLLI: begin dec.kind = K_SLL;  dec.use_imm = 1'b1; end
      OP_ADD:  dec.kind = K_ADD;
      OP_ADDI: begin dec.kind = K_ADD;  dec.use_imm = 1'b1; end
      OP_SUB:  dec.kind = K_SUB;
      OP_MUL:  dec.kind = K_MUL;
      OP_DIV:  dec.kind = K_DIV;
      OP_REM:  dec.kind = K_REM;
      default: dec.legal = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != (PW+1)'(QD));
  assign push      = in_tvalid && in_tready;
  assign head_vld  = (cnt_r != '0);
  assign head      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- src/rial_exec.sv -----
// Back end: register file read, ALU, iterative multiply/divide, write-back.
module rial_exec
  import rial_pkg::*;
#(
  parameter int unsigned XLEN     = 64,
  parameter int unsigned NUM_REGS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            head,
  input  logic             head_vld,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int unsigned CW  = $clog2(XLEN);
  localparam int unsigned SHW = (XLEN > 32) ? 6 : 5;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state_r;
  item_t                cur_r;
  logic [NUM_REGS-1:0]  vld_r;
  logic                 va_r, vb_r;
  logic [XLEN-1:0]      rd1, rd2, a, b, immx, op2, alu;
  logic [XLEN-1:0]      acc_r, mca_r, mcb_r, res_r;
  logic [CW-1:0]        cnt_r;
  logic                 direct_r, na_r, nb_r;
  logic                 we;
  logic [XLEN-1:0]      fin_val;
  logic [XLEN:0]        dtmp, ddif;
  logic                 dge;
  logic                 out_free;
  logic                 out_vld_r;
  logic [RIDX_W-1:0]    out_rd_r;
  logic [63:0]          out_val_r;
  logic                 out_wr_r;

  rial_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(we), .waddr(cur_r.rd), .wdata(fin_val),
    .raddr(head.rs1), .rdata(rd1)
  );
  rial_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(we), .waddr(cur_r.rd), .wdata(fin_val),
    .raddr(head.rs2), .rdata(rd2)
  );

  assign pop  = (state_r == S_IDLE) && head_vld;
  assign a    = va_r ? rd1 : '0;
  assign b    = vb_r ? rd2 : '0;
  assign immx = XLEN'(signed'(cur_r.imm));
  assign op2  = cur_r.use_imm ? immx : b;

  always_comb begin
    case (cur_r.kind)
      K_LI:    alu = immx;
      K_AND:   alu = a & op2;
      K_OR:    alu = a | op2;
      K_XOR:   alu = a ^ op2;
      K_SLT:   alu = XLEN'($signed(a) < $signed(op2));
      K_SLTU:  alu = XLEN'(a < op2);
      K_SRL:   alu = a >> op2[SHW-1:0];
      K_SLL:   alu = a << op2[SHW-1:0];
      K_ADD:   alu = a + op2;
      K_SUB:   alu = a - op2;
      default: alu = '0;
    endcase
  end

  // one restoring divide step
  assign dtmp = {acc_r, mca_r[XLEN-1]};
  assign ddif = dtmp - {1'b0, mcb_r};
  assign dge  = !ddif[XLEN];

  always_comb begin
    if (direct_r) begin
      fin_val = res_r;
    end else if (cur_r.kind == K_MUL) begin
      fin_val = acc_r;
    end else if (cur_r.kind == K_DIV) begin
      fin_val = (na_r != nb_r) ? -mca_r : mca_r;
    end else begin
      fin_val = na_r ? -acc_r : acc_r;
    end
  end

  assign out_free = !out_vld_r || out_tready;
  assign we = (state_r == S_FIN) && out_free && cur_r.legal && (cur_r.rd != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (head_vld) state_r <= S_EXEC;
        S_EXEC: begin
          if ((cur_r.kind == K_MUL) ||
              (((cur_r.kind == K_DIV) || (cur_r.kind == K_REM)) && (b != '0))) begin
            state_r <= S_ITER;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_ITER: if (cnt_r == '0) state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            if (we) vld_r[cur_r.rd] <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cur_r <= head;
        va_r  <= vld_r[head.rs1];
        vb_r  <= vld_r[head.rs2];
      end
      S_EXEC: begin
        acc_r    <= '0;
        cnt_r    <= CW'(XLEN-1);
        na_r     <= a[XLEN-1];
        nb_r     <= b[XLEN-1];
        if (cur_r.kind == K_MUL) begin
          direct_r <= 1'b0;
          mca_r    <= a;
          mcb_r    <= b;
        end else if ((cur_r.kind == K_DIV) || (cur_r.kind == K_REM)) begin
          // divide by zero takes the direct path
          direct_r <= (b == '0);
          res_r    <= (cur_r.kind == K_DIV) ? '1 : a;
          mca_r    <= a[XLEN-1] ? -a : a;
          mcb_r    <= b[XLEN-1] ? -b : b;
        end else begin
          direct_r <= 1'b1;
          res_r    <= alu;
        end
      end
      S_ITER: begin
        cnt_r <= cnt_r - 1'b1;
        if (cur_r.kind == K_MUL) begin
          if (mcb_r[0]) acc_r <= acc_r + mca_r;
          mca_r <= mca_r << 1;
          mcb_r <= mcb_r >> 1;
        end else begin
          acc_r <= dge ? ddif[XLEN-1:0] : dtmp[XLEN-1:0];
          mca_r <= {mca_r[XLEN-2:0], dge};
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_rd_r  <= cur_r.rd;
          out_val_r <= cur_r.legal ? 64'(signed'(fin_val)) : '0;
          out_wr_r  <= cur_r.legal && (cur_r.rd != '0);
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_wr_r, out_val_r, out_rd_r};

endmodule

// ----- src/risc_integer_alu_regfile.sv -----
// Top level of the integer ALU with a 32-entry register file.
// Logic, compare, shift, add and li pass from the queue through the idle, execute
//   and finish states into the output register; mul, div and rem also iterate, one
//   bit per cycle, but div and rem by zero take the direct path. One instruction at a time
//   is in the execute unit, and a result stall holds it; a 4-deep queue accepts until full.
// Reset: rst_n synchronous active low; clears queue, state, output valid and
//   the per-register valid bits, so every register reads as zero afterwards.
module risc_integer_alu_regfile
  import rial_pkg::*;
#(
  parameter int unsigned XLEN     = 64,
  parameter int unsigned NUM_REGS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // operation[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15],
  // imm[51:20], zero fill [55:52]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // dest_index[4:0], result_value[68:5], wrote[69], zero fill [71:70]
  output logic [OUT_W-1:0] out_tdata
);

  item_t head;
  logic  head_vld;
  logic  pop;

  // front: decode and queue each accepted transaction
  rial_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .head(head), .head_vld(head_vld), .pop(pop)
  );

  // back: read operands, execute, write back, hold result in output register
  rial_exec #(.XLEN(XLEN), .NUM_REGS(NUM_REGS)) u_exec (
    .clk(clk), .rst_n(rst_n),
    .head(head), .head_vld(head_vld), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

// ----- src/rial_chk.sv -----
// Port-level checker for the integer ALU, bound to the top level.
module rial_chk
  import rial_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction dropped or changed while stalled");

  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[69] && (out_tdata[4:0] == '0)))
    else $error("write to register zero reported");

  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[69] && (out_tdata[4:0] != '0) |-> (out_tdata[68:5] == '0))
    else $error("illegal instruction with nonzero result");

endmodule

bind risc_integer_alu_regfile rial_chk u_chk (.*);

// ----- verif/risc_integer_alu_regfile_checker.sv -----
// Checker for the integer ALU: predicts each instruction's result and compares it.
module risc_integer_alu_regfile_checker
  import rial_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        wrote;
    logic [63:0] value;
    logic [4:0]  dest;
  } alu_result_t;

  logic [63:0] gpr_model [32];
  alu_result_t result_fifo [$];

  assign pending = result_fifo.size();

  function automatic logic [63:0] divide_rv(logic [63:0] a, logic [63:0] b, bit want_rem);
    logic [63:0] ma, mb, q, r;
    bit na, nb;
    if (b == '0) return want_rem ? a : '1;
    na = a[63];
    nb = b[63];
    ma = na ? -a : a;
    mb = nb ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (na != nb) q = -q;
    if (na) r = -r;
    return want_rem ? r : q;
  endfunction

  function automatic alu_result_t execute(logic [IN_W-1:0] d);
    logic [4:0] op, rd;
    logic [63:0] a, b, im, v;
    alu_result_t res;
    bit legal;
    op = d[4:0];
    rd = d[9:5];
    a = (d[14:10] == 0) ? '0 : gpr_model[d[14:10]];
    b = (d[19:15] == 0) ? '0 : gpr_model[d[19:15]];
    im = {{32{d[51]}}, d[51:20]};
    legal = 1;
    v = '0;
    case (op)
      OP_LI:    v = im;
      OP_AND:   v = a & b;
      OP_ANDI:  v = a & im;
      OP_OR:    v = a | b;
      OP_ORI:   v = a | im;
      OP_XOR:   v = a ^ b;
      OP_XORI:  v = a ^ im;
      OP_SLT:   v = {63'd0, $signed(a) < $signed(b)};
      OP_SLTI:  v = {63'd0, $signed(a) < $signed(im)};
      OP_SLTU:  v = {63'd0, a < b};
      OP_SLTIU: v = {63'd0, a < im};
      OP_SRL:   v = a >> b[5:0];
      OP_SRLI:  v = a >> im[5:0];
      OP_SLL:   v = a << b[5:0];
      OP_SLLI:  v = a << im[5:0];
      OP_ADD:   v = a + b;
      OP_ADDI:  v = a + im;
      OP_SUB:   v = a - b;
      OP_MUL:   v = a * b;
      OP_DIV:   v = divide_rv(a, b, 0);
      OP_REM:   v = divide_rv(a, b, 1);
      default:  legal = 0;
    endcase
    res.dest = rd;
    res.value = legal ? v : '0;
    res.wrote = legal && rd != 0;
    if (res.wrote) gpr_model[rd] = v;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    alu_result_t got, want;
    if (!rst_n) begin
      foreach (gpr_model[i]) gpr_model[i] = '0;
      result_fifo.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) result_fifo.insert(result_fifo.size(), execute(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[69:0];
        if (result_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: dest %0d/%0d value %h/%h wrote %b/%b (exp/act)",
                want.dest, got.dest, want.value, got.value, want.wrote, got.wrote);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- verif/risc_integer_alu_regfile_test.sv -----
// Testbench top: drives instruction stimulus into the integer ALU and reports the verdict.
module risc_integer_alu_regfile_test
  import rial_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1100;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  bit               calm = 0;    // set in the last part: no more idling

  always #5 clk = ~clk;

  risc_integer_alu_regfile u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  risc_integer_alu_regfile_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending
  );

  // Stall the result side in random bursts until the calm tail.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold the item until the transaction happens, then idle at random.
  task automatic send_instr(logic [4:0] op, logic [4:0] rd, logic [4:0] rs1,
                            logic [4:0] rs2, logic [31:0] imm);
    int n;
    in_tdata  <= {4'd0, imm, rs2, rs1, rd, op};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 3);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 127);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_op();
    // Mostly legal ops, with slow mul/div/rem picked rarely to bound run time.
    case ($urandom_range(0, 19))
      0: return OP_ILLEGAL + 5'($urandom_range(0, 1) ? 0 : $urandom_range(22, 31));
      1, 2: return 5'($urandom_range(OP_MUL, OP_REM));
      default: return 5'($urandom_range(OP_LI, OP_SUB));
    endcase
  endfunction

  initial begin
    logic [4:0] op;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extreme values, divide special cases, register 0, illegal ops.
    send_instr(OP_LI,   5'd1, 5'd0, 5'd0, 32'h8000_0000);
    send_instr(OP_LI,   5'd2, 5'd0, 5'd0, 32'hffff_ffff);
    send_instr(OP_LI,   5'd3, 5'd0, 5'd0, 32'h7fff_ffff);
    send_instr(OP_SLLI, 5'd4, 5'd1, 5'd0, 32'd32);          // most negative 64-bit
    send_instr(OP_DIV,  5'd5, 5'd4, 5'd2, 32'd0);           // signed overflow
    send_instr(OP_REM,  5'd6, 5'd4, 5'd2, 32'd0);
    send_instr(OP_DIV,  5'd7, 5'd3, 5'd0, 32'd0);           // divide by zero
    send_instr(OP_REM,  5'd8, 5'd3, 5'd0, 32'd0);
    send_instr(OP_DIV,  5'd9, 5'd1, 5'd3, 32'd0);
    send_instr(OP_REM,  5'd10, 5'd2, 5'd3, 32'd0);
    send_instr(OP_MUL,  5'd11, 5'd4, 5'd2, 32'd0);
    send_instr(OP_SRL,  5'd12, 5'd2, 5'd2, 32'd0);          // amount 63 masked
    send_instr(OP_SRLI, 5'd13, 5'd1, 5'd0, 32'hffff_ffc1);
    send_instr(OP_SLL,  5'd14, 5'd2, 5'd3, 32'd0);
    send_instr(OP_SLT,  5'd15, 5'd4, 5'd3, 32'd0);
    send_instr(OP_SLTU, 5'd16, 5'd4, 5'd3, 32'd0);
    send_instr(OP_SLTI, 5'd17, 5'd3, 5'd0, 32'h8000_0000);
    send_instr(OP_SLTIU, 5'd18, 5'd3, 5'd0, 32'hffff_ffff);
    send_instr(OP_ADDI, 5'd0, 5'd3, 5'd0, 32'd1);           // dest zero dropped
    send_instr(OP_ADD,  5'd19, 5'd0, 5'd3, 32'd0);
    send_instr(OP_SUB,  5'd20, 5'd0, 5'd4, 32'd0);
    send_instr(OP_ANDI, 5'd21, 5'd2, 5'd0, 32'h5555_aaaa);
    send_instr(OP_ORI,  5'd22, 5'd1, 5'd0, 32'h0f0f_0f0f);
    send_instr(OP_XORI, 5'd31, 5'd2, 5'd0, 32'h1234_5678);
    send_instr(5'd31,   5'd23, 5'd1, 5'd2, 32'hffff_ffff);  // unknown op

    // Random: mostly legal instructions on random registers.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 150) calm = 1;
      op = pick_op();
      send_instr(op, 5'($urandom), 5'($urandom), 5'($urandom), pick_imm());
    end
    in_tvalid <= 0;

    // Drain and let the pipeline settle.
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- files.f -----
src/rial_pkg.sv
src/rial_ram.sv
src/rial_front.sv
src/rial_exec.sv
src/risc_integer_alu_regfile.sv
src/rial_chk.sv
verif/risc_integer_alu_regfile_checker.sv
verif/risc_integer_alu_regfile_test.sv
